// ----- hw/rtl/nbac_pkg.sv -----
`default_nettype none

package nbac_pkg;

  // input sample and millivolt widths
  localparam int ADC_W = 12;
  localparam int MV_W = 12;

  // result field width, signed degrees celsius
  localparam int TEMP_W = 9;
  localparam int TEMP_OFFSET = 40;

  // supply scale in millivolts and adc code count as a power of two
  localparam int FULL_SCALE_MV = 3350;
  localparam int ADC_CODE_BITS = 12;

  // voltage table, descending, -40 c to +129 c in 1 c steps
  localparam int TABLE_LEN = 170;
  localparam int IDX_W = 8;

  // depth of the queue between accumulator and converter
  localparam int QUEUE_DEPTH = 2;

  // only 166 entries carry a voltage, the last four are zero, so any
  // nonzero value matches by the first zero entry at the latest
  localparam logic [MV_W-1:0] VOLT_TABLE [TABLE_LEN] = '{
    12'd3193, 12'd3185, 12'd3175, 12'd3166, 12'd3156, 12'd3146, 12'd3135, 12'd3124,
    12'd3112, 12'd3100, 12'd3088, 12'd3075, 12'd3061, 12'd3047, 12'd3032, 12'd3017,
    12'd3002, 12'd2985, 12'd2968, 12'd2951, 12'd2933, 12'd2914, 12'd2895, 12'd2875,
    12'd2855, 12'd2834, 12'd2813, 12'd2791, 12'd2768, 12'd2745, 12'd2722, 12'd2698,
    12'd2673, 12'd2648, 12'd2623, 12'd2597, 12'd2570, 12'd2543, 12'd2516, 12'd2488,
    12'd2460, 12'd2431, 12'd2402, 12'd2373, 12'd2343, 12'd2313, 12'd2282, 12'd2251,
    12'd2220, 12'd2189, 12'd2158, 12'd2126, 12'd2094, 12'd2062, 12'd2030, 12'd1998,
    12'd1965, 12'd1933, 12'd1900, 12'd1868, 12'd1835, 12'd1803, 12'd1771, 12'd1739,
    12'd1707, 12'd1675, 12'd1643, 12'd1612, 12'd1581, 12'd1550, 12'd1519, 12'd1489,
    12'd1459, 12'd1429, 12'd1400, 12'd1371, 12'd1342, 12'd1314, 12'd1286, 12'd1258,
    12'd1231, 12'd1204, 12'd1178, 12'd1152, 12'd1127, 12'd1102, 12'd1077, 12'd1053,
    12'd1029, 12'd1006, 12'd983,  12'd961,  12'd938,  12'd917,  12'd896,  12'd875,
    12'd854,  12'd835,  12'd815,  12'd796,  12'd777,  12'd759,  12'd741,  12'd723,
    12'd706,  12'd689,  12'd673,  12'd657,  12'd641,  12'd626,  12'd611,  12'd596,
    12'd582,  12'd568,  12'd554,  12'd541,  12'd528,  12'd515,  12'd503,  12'd491,
    12'd479,  12'd468,  12'd456,  12'd446,  12'd435,  12'd419,  12'd414,  12'd405,
    12'd395,  12'd386,  12'd377,  12'd368,  12'd359,  12'd351,  12'd342,  12'd334,
    12'd327,  12'd319,  12'd312,  12'd305,  12'd298,  12'd291,  12'd284,  12'd278,
    12'd271,  12'd265,  12'd259,  12'd253,  12'd248,  12'd242,  12'd237,  12'd232,
    12'd227,  12'd222,  12'd217,  12'd212,  12'd207,  12'd203,  12'd199,  12'd194,
    12'd190,  12'd186,  12'd182,  12'd178,  12'd175,  12'd171,  12'd0,    12'd0,
    12'd0,    12'd0
  };

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } nbac_qstat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ntc_block_average_to_celsius.sv -----
// path: the sample that completes a block pushes its sum into the queue; the converter then
//   pops it, runs one reciprocal scaling step and a linear table scan of 170 entries, then raises out_tvalid
// throughput: one sample per cycle while the two-entry block queue has room; the
//   converter finishes each block, any output stall included, before it pops the next one
// reset: rst_n synchronous active low; clears sample count, running sum, queue and
//   converter state; no clearing pass, the block is ready the cycle after reset
`default_nettype none

module ntc_block_average_to_celsius #(
  parameter int SAMPLES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // sample stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] adc_sample, [15:12] ignored
  // result stream, one item per completed block
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [8:0] temp_celsius (signed), [15:9] zero
  output logic             out_tuser   // [0] no_match
);
  import nbac_pkg::*;

  // running sum must hold SAMPLES full-scale samples
  localparam int SUM_W = $clog2(SAMPLES * 4095 + 1);

  nbac_qstat_t              q_stat;
  logic                     push;
  logic                     pop;
  logic [SUM_W-1:0]         push_data;
  logic [SUM_W-1:0]         pop_data;
  logic signed [TEMP_W-1:0] temp;
  logic                     miss;

  // front: accumulates samples, hands each block sum to the queue
  nbac_front #(
    .SAMPLES (SAMPLES),
    .SUM_W   (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sample    (in_tdata[ADC_W-1:0]),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // short queue of block sums, lets the accumulator run while the converter works
  nbac_queue #(
    .W     (SUM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // back: scale to millivolts, search the voltage table, hold the result
  nbac_back #(
    .SAMPLES (SAMPLES),
    .SUM_W   (SUM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_data     (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .temp       (temp),
    .miss       (miss)
  );

  // pack result, temperature in the low bits, zero fill to 16 bits
  assign out_tdata = {{(16 - TEMP_W){1'b0}}, temp};
  assign out_tuser = miss;

endmodule

`default_nettype wire

// ----- hw/rtl/nbac_front.sv -----
`default_nettype none

module nbac_front #(
  parameter int SAMPLES = 16,
  parameter int SUM_W = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [nbac_pkg::ADC_W-1:0] sample,
  input  wire nbac_pkg::nbac_qstat_t     q_stat,
  output logic                           push,
  output logic [SUM_W-1:0]               push_data
);
  import nbac_pkg::*;

  localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] sum_add;
  logic             accept;

  // a completed block always finds room, since ready waits on the queue
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign sum_add   = sum_r + SUM_W'(sample);
  assign push_data = sum_add;

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    push    = 1'b0;
    if (accept) begin
      if (cnt_r == LAST_CNT) begin
        cnt_nxt = '0;
        sum_nxt = '0;
        push    = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        sum_nxt = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nbac_queue.sv -----
`default_nettype none

module nbac_queue #(
  parameter int W = 16,
  parameter int DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire logic [W-1:0]          push_data,
  input  wire logic                  pop,
  output logic [W-1:0]               pop_data,
  output nbac_pkg::nbac_qstat_t      q_stat
);
  import nbac_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a lone push");

endmodule

`default_nettype wire

// ----- hw/rtl/nbac_back.sv -----
`default_nettype none

module nbac_back #(
  parameter int SAMPLES = 16,
  parameter int SUM_W = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire nbac_pkg::nbac_qstat_t             q_stat,
  input  wire logic [SUM_W-1:0]                  q_data,
  output logic                                   pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic signed [nbac_pkg::TEMP_W-1:0]     temp,
  output logic                                   miss
);
  import nbac_pkg::*;

  // sum times full scale, then divide by 4096 * SAMPLES: drop the adc code
  // bits, then a rounded-up reciprocal multiply, exact for any SUM_W-bit value
  localparam int PROD_W    = SUM_W + ADC_CODE_BITS;
  localparam int RCP_LOG   = (SAMPLES > 1) ? $clog2(SAMPLES) : 0;
  localparam int RCP_SHIFT = SUM_W + RCP_LOG;
  localparam int RCP_W     = SUM_W + 2;
  localparam int SCALED_W  = SUM_W + RCP_W;
  localparam longint RCP_L =
    ((longint'(1) << RCP_SHIFT) + longint'(SAMPLES) - 1) / longint'(SAMPLES);
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_L);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_LEN - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCALE = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [PROD_W-1:0]         prod_r, prod_nxt;
  logic [SCALED_W-1:0]       scaled;
  logic [MV_W-1:0]           mv_r, mv_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic signed [TEMP_W-1:0]  res_temp_r, res_temp_nxt;
  logic                      res_miss_r, res_miss_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [TEMP_W-1:0]  temp_r;
  logic                      miss_r;
  logic                      out_load;
  logic [MV_W-1:0]           entry;

  assign entry      = VOLT_TABLE[idx_r];
  assign scaled     = SCALED_W'(prod_r[PROD_W-1:ADC_CODE_BITS]) * SCALED_W'(RECIP);
  assign out_tvalid = out_valid_r;
  assign temp       = temp_r;
  assign miss       = miss_r;

  always_comb begin
    state_nxt    = state_r;
    prod_nxt     = prod_r;
    mv_nxt       = mv_r;
    idx_nxt      = idx_r;
    res_temp_nxt = res_temp_r;
    res_miss_nxt = res_miss_r;
    pop          = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          prod_nxt  = PROD_W'(q_data) * PROD_W'(FULL_SCALE_MV);
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        // quotient sits above the reciprocal shift
        mv_nxt    = scaled[RCP_SHIFT +: MV_W];
        idx_nxt   = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (mv_r > entry) begin
          res_temp_nxt = TEMP_W'(idx_r) - TEMP_W'(TEMP_OFFSET);
          res_miss_nxt = 1'b0;
          state_nxt    = ST_DONE;
        end else if (idx_r == LAST_IDX) begin
          res_temp_nxt = '0;
          res_miss_nxt = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    mv_r       <= mv_nxt;
    idx_r      <= idx_nxt;
    res_temp_r <= res_temp_nxt;
    res_miss_r <= res_miss_nxt;
    if (out_load) begin
      temp_r <= res_temp_r;
      miss_r <= res_miss_r;
    end
  end

  a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (mv_r < MV_W'(FULL_SCALE_MV)))
    else $error("millivolt value out of range");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && miss_r) |-> (temp_r == '0))
    else $error("no-match result with nonzero temperature");

  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !out_load)
    else $error("output register overwritten while held");

endmodule

`default_nettype wire
